/* rtl/bsrm_pkg.sv */
// Shared types and constants for the backing-store range map table.
package bsrm_pkg;

	localparam int NUM_STORES    = 8;
	localparam int IDX_W         = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
	localparam int PAGE_SHIFT    = 12;
	localparam int MAX_MAP_PAGES = 256;

	typedef enum logic [2:0] {
		ACT_CLEAR  = 3'd0,
		ACT_ALLOC  = 3'd1,
		ACT_FREE   = 3'd2,
		ACT_MAP    = 3'd3,
		ACT_UNMAP  = 3'd4,
		ACT_LOOKUP = 3'd5
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_OP
	} state_t;

	typedef struct packed {
		action_t     action;
		logic [5:0]  pid;
		logic        pid_live;
		logic [31:0] virt_addr;
		logic [19:0] page_number;
		logic [3:0]  store_index;
		logic [8:0]  page_count;
	} req_t;

	typedef struct packed {
		logic       status;
		logic [3:0] found_store;
		logic [7:0] page_offset;
	} res_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_act;
		logic hit;
		logic last;
	} sts_t;

endpackage

/* rtl/backing_store_range_map_table.sv */
// Top level of the backing-store range map table.
//
//   channel   handshake          payload
//   request   start / busy       request (req_t)
//   result    done (one cycle)   result (res_t)
//
// A request is taken when start is high and busy is low. Clear all, free,
// map and undefined actions do not scan the table; allocate, unmap and
// lookup walk the table one entry a cycle, stopping at the first hit or at
// the last entry. The result word appears on the cycle after the last
// datapath cycle, when busy is already low; no new request is taken while
// one is in the datapath. Reset unmaps every entry at once.
module backing_store_range_map_table
	import bsrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	cmd_t cmd;
	sts_t sts;

	bsrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bsrm_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

/* rtl/bsrm_ctrl.sv */
// Controller state machine: sequences one request through the datapath.
module bsrm_ctrl
	import bsrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_OP;
				end
			end
			ST_OP: begin
				// Scanning requests walk one entry a cycle until a hit or the last entry.
				if (sts.scan_act) begin
					cmd.step   = 1'b1;
					cmd.finish = sts.hit || sts.last;
				end else begin
					cmd.finish = 1'b1;
				end
				if (cmd.finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

/* rtl/bsrm_dpath.sv */
// Datapath: entry table, scan counter, match logic and result register.
module bsrm_dpath
	import bsrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t result
);

	req_t             req_q;
	logic [IDX_W-1:0] scan_q;
	res_t             res_q;
	res_t             res_d;

	logic [NUM_STORES-1:0] mapped_q;
	logic [5:0]            owner_q [NUM_STORES];
	logic [19:0]           first_q [NUM_STORES];
	logic [8:0]            pages_q [NUM_STORES];

	logic [IDX_W-1:0] idx_lo;
	logic [IDX_W-1:0] rd_sel;
	logic             idx_ok;
	logic             e_mapped;
	logic [5:0]       e_owner;
	logic [19:0]      e_first;
	logic [8:0]       e_pages;
	logic [19:0]      vpage;
	logic [20:0]      range_end;
	logic [19:0]      page_diff;
	logic             owner_match;
	logic             in_range;
	logic             count_ok;
	logic             map_ok;
	logic             hit;
	logic             scan_act;

	assign idx_lo = req_q.store_index[IDX_W-1:0];
	assign idx_ok = ({1'b0, req_q.store_index} < 5'(NUM_STORES));
	assign rd_sel = scan_act ? scan_q : idx_lo;

	assign e_mapped = mapped_q[rd_sel];
	assign e_owner  = owner_q[rd_sel];
	assign e_first  = first_q[rd_sel];
	assign e_pages  = pages_q[rd_sel];

	assign vpage       = req_q.virt_addr[31:PAGE_SHIFT];
	assign range_end   = {1'b0, e_first} + {12'd0, e_pages};
	assign page_diff   = vpage - e_first;
	assign owner_match = req_q.pid_live && e_mapped && (e_owner == req_q.pid);
	assign in_range    = (vpage >= e_first) && ({1'b0, vpage} < range_end);
	assign count_ok    = (req_q.page_count != 9'd0) &&
	                     (req_q.page_count <= 9'(MAX_MAP_PAGES));
	assign map_ok      = req_q.pid_live && idx_ok && count_ok &&
	                     !(e_mapped && (e_owner != req_q.pid));

	always_comb begin
		hit      = 1'b0;
		scan_act = 1'b0;
		case (req_q.action)
			ACT_ALLOC: begin
				scan_act = 1'b1;
				hit      = !e_mapped;
			end
			ACT_UNMAP: begin
				scan_act = 1'b1;
				hit      = owner_match && (e_first == req_q.page_number);
			end
			ACT_LOOKUP: begin
				scan_act = 1'b1;
				hit      = owner_match && in_range;
			end
			default: begin
				scan_act = 1'b0;
			end
		endcase
	end

	assign sts.scan_act = scan_act;
	assign sts.hit      = hit;
	assign sts.last     = (scan_q == IDX_W'(NUM_STORES - 1));

	always_comb begin
		res_d = '{status: 1'b1, found_store: 4'd0, page_offset: 8'd0};
		case (req_q.action)
			ACT_CLEAR: begin
				res_d.status = 1'b0;
			end
			ACT_ALLOC: begin
				if (hit) begin
					res_d.status      = 1'b0;
					res_d.found_store = 4'(scan_q);
				end
			end
			ACT_FREE: begin
				res_d.status = !idx_ok;
			end
			ACT_MAP: begin
				res_d.status = !map_ok;
			end
			ACT_UNMAP: begin
				res_d.status = !hit;
			end
			ACT_LOOKUP: begin
				if (hit) begin
					res_d.status      = 1'b0;
					res_d.found_store = 4'(scan_q);
					res_d.page_offset = page_diff[7:0];
				end
			end
			default: begin
				res_d.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped_q <= '0;
		end else if (cmd.finish) begin
			case (req_q.action)
				ACT_CLEAR: begin
					mapped_q <= '0;
				end
				ACT_FREE: begin
					if (idx_ok) begin
						mapped_q[idx_lo] <= 1'b0;
					end
				end
				ACT_MAP: begin
					if (map_ok) begin
						mapped_q[idx_lo] <= 1'b1;
					end
				end
				ACT_UNMAP: begin
					if (hit) begin
						mapped_q[scan_q] <= 1'b0;
					end
				end
				default: begin
					mapped_q <= mapped_q;
				end
			endcase
		end
	end

	// Entry fields are only looked at while the entry is mapped, so they need no reset.
	always_ff @(posedge clk) begin
		if (cmd.finish && (req_q.action == ACT_MAP) && map_ok) begin
			owner_q[idx_lo] <= req_q.pid;
			first_q[idx_lo] <= req_q.page_number;
			pages_q[idx_lo] <= req_q.page_count;
		end
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.load) begin
			scan_q <= '0;
		end else if (cmd.step) begin
			scan_q <= scan_q + IDX_W'(1);
		end
	end

	assign result = res_q;

endmodule

/* rtl/bsrm_chk.sv */
// Port-level checker for the backing-store range map table, with its bind.
module bsrm_chk
	import bsrm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic done,
	input res_t result
);

	// A result word only comes out once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result word");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> (result.found_store == 4'd0) &&
		                         (result.page_offset == 8'd0))
		else $error("failed result carries nonzero fields");

endmodule

bind backing_store_range_map_table bsrm_chk u_bsrm_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);
